// File: hw/rtl/kls_pkg.sv
// Package for the keyframe linear sampler: payload words, opcodes, widths.
// No dependencies.
`timescale 1ns / 1ps
package kls_pkg;
  localparam int TimeW = 24;
  localparam int ValW  = 32;
  localparam int SegW  = 6;
  localparam int CntW  = 7;

  // key table depth and its address width
  localparam int MaxKeys = 64;
  localparam int AddrW   = 6;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_SEG  = 1'b1;

  // configuration register addresses
  localparam logic [1:0] REG_KEY_COUNT = 2'd0;

  // kind of result word held on the output
  typedef enum logic [1:0] {
    KIND_LERP, KIND_SINGLE, KIND_NONE
  } kind_t;

  typedef struct packed {
    logic              opcode;
    logic [5:0]        key_index;
    logic [TimeW-1:0]  key_time;
    logic signed [ValW-1:0] key_x;
    logic signed [ValW-1:0] key_y;
    logic signed [ValW-1:0] key_z;
    logic [TimeW-1:0]  sample_time;
  } in_word_t;

  typedef struct packed {
    logic signed [ValW-1:0] out_x;
    logic signed [ValW-1:0] out_y;
    logic signed [ValW-1:0] out_z;
    logic [SegW-1:0]   segment;
    logic              status;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // write key table from input word
    logic latch;       // capture sample time
    logic rd;          // issue table read at rd_addr
    logic div_start;   // start factor division
    logic lerp_step;   // advance interpolation over one component
    logic set_cache;   // record segment
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic lerp_done;
  } dp_stat_t;
endpackage

// File: hw/rtl/keyframe_linear_sampler_core.sv
// Keyframe linear sampler top level. Loads are taken every cycle while no sample is
// busy. A sample tries the cached segment first if it is valid, then scans the keys;
// a factor of 0 or 1 skips the divider. A single key gives the value of key 0. busy
// stays high until the result cycle. Receiver cannot stall: the result shows for one
// cycle with done. Synchronous reset sets key_count to 1 and the cached segment to 0;
// key tables are undefined until loaded.
`timescale 1ns / 1ps
module keyframe_linear_sampler_core (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  kls_pkg::in_word_t  in_word,
  output logic done,
  output kls_pkg::out_word_t out_word,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import kls_pkg::*;

  logic [CntW-1:0] key_count;
  assign pready = 1'b1;
  assign prdata = {25'd0, key_count};
  always_ff @(posedge clk) begin
    if (rst) key_count <= CntW'(1);
    else if (psel && penable && pwrite && paddr == REG_KEY_COUNT)
      key_count <= pwdata[CntW-1:0];
  end

  // accepted word held for the datapath
  in_word_t in_hold;
  always_ff @(posedge clk) begin
    if (start && !busy) in_hold <= in_word;
  end

  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [AddrW-1:0] rd_addr, seg, cache;
  logic [TimeW-1:0] rd_time, t_smp;
  logic [3*ValW-1:0] res;
  kind_t kind;
  logic cdone;

  // single-key value comes straight from the read register of slot 0
  logic [3*ValW-1:0] single_val;

  kls_ctrl u_ctrl (
    .clk, .rst, .start, .opcode(in_word.opcode), .key_count, .rd_time, .t_smp,
    .cache, .stat, .cmd, .rd_addr, .seg, .busy, .done(cdone), .kind
  );

  kls_datapath u_dp (
    .clk, .rst, .in_word(in_hold), .cmd, .rd_addr, .seg, .rd_time,
    .rd_val(single_val), .t_smp, .cache, .stat, .res
  );

  always_comb begin
    done = cdone;
    out_word = '0;
    case (kind)
      KIND_LERP: begin
        out_word.out_x = res[3*ValW-1:2*ValW];
        out_word.out_y = res[2*ValW-1:ValW];
        out_word.out_z = res[ValW-1:0];
        out_word.segment = SegW'(seg);
      end
      KIND_SINGLE: begin
        out_word.out_x = single_val[3*ValW-1:2*ValW];
        out_word.out_y = single_val[2*ValW-1:ValW];
        out_word.out_z = single_val[ValW-1:0];
      end
      default: out_word.status = ST_NO_SEG;
    endcase
  end
endmodule

// File: hw/rtl/kls_datapath.sv
// Datapath of the keyframe sampler: key memories, serial divider and
// one-component-a-cycle interpolator. Depends on kls_pkg.
`timescale 1ns / 1ps
module kls_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  kls_pkg::in_word_t     in_word,
  input  kls_pkg::dp_cmd_t      cmd,
  input  logic [kls_pkg::AddrW-1:0] rd_addr,
  input  logic [kls_pkg::AddrW-1:0] seg,
  output logic [kls_pkg::TimeW-1:0] rd_time,
  output logic [3*kls_pkg::ValW-1:0] rd_val,
  output logic [kls_pkg::TimeW-1:0] t_smp,
  output logic [kls_pkg::AddrW-1:0] cache,
  output kls_pkg::dp_stat_t     stat,
  output logic [3*kls_pkg::ValW-1:0] res
);
  import kls_pkg::*;

  logic [TimeW-1:0] tmem [MaxKeys];
  logic [3*ValW-1:0] vmem [MaxKeys];
  logic [3*ValW-1:0] v0, v1;
  logic [TimeW-1:0] t0;
  logic div_done, lerp_done;

  assign stat = {div_done, lerp_done};

  // key memories: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.load && (32'(in_word.key_index) < MaxKeys))begin
      tmem[in_word.key_index[AddrW-1:0]] <= in_word.key_time;
      vmem[in_word.key_index[AddrW-1:0]] <= {in_word.key_x, in_word.key_y, in_word.key_z};
    end
    if (cmd.rd) begin
      rd_time <= tmem[rd_addr];
      rd_val  <= vmem[rd_addr];
    end
  end

  // sample time and cached segment
  always_ff @(posedge clk) begin
    if (rst) cache <= '0;
    else if (cmd.set_cache) cache <= seg;
    if (cmd.latch) t_smp <= in_word.sample_time;
  end

  // endpoint capture: controller reads start key then end key
  always_ff @(posedge clk) begin
    if (cmd.set_cache) begin
      t0 <= rd_time; v0 <= rd_val;
    end
    if (cmd.div_start) v1 <= rd_val;
  end

  // restoring divider: 16 quotient bits of ((t-t0)<<16)/(t1-t0)
  logic [TimeW:0] rem;
  logic [TimeW-1:0] dvs;
  logic [16:0] quo;
  logic [4:0] dcnt;
  logic dbusy;
  logic [TimeW:0] trial;
  logic [16:0] fac;
  assign trial = {rem[TimeW-1:0], 1'b0};
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0; div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        if (rd_time <= t0 || t_smp <= t0) begin
          fac <= '0; div_done <= 1'b1;
        end else if (t_smp - t0 >= rd_time - t0) begin
          fac <= 17'h10000; div_done <= 1'b1;
        end else begin
          dvs <= rd_time - t0;
          rem <= {1'b0, t_smp - t0}; quo <= '0;
          dcnt <= 5'd16; dbusy <= 1'b1;
        end
      end else if (dbusy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs}; quo <= {quo[15:0], 1'b1};
        end else begin
          rem <= trial; quo <= {quo[15:0], 1'b0};
        end
        if (dcnt == 5'd1) begin
          dbusy <= 1'b0; div_done <= 1'b1;
          fac <= (trial >= {1'b0, dvs}) ? {quo[15:0], 1'b1} : {quo[15:0], 1'b0};
        end
        dcnt <= dcnt - 5'd1;
      end
    end
  end
  // first quotient bit step: since num<dvs the integer part is zero; rem starts at num

  // interpolator: one component per cycle, product registered
  logic [1:0] lcnt;
  logic signed [ValW:0] d;
  logic signed [ValW+17:0] prod;
  logic signed [ValW-1:0] s_a, s_b, s_hold;
  logic pvalid;
  always_comb begin
    unique case (lcnt)
      2'd0: begin s_a = v0[3*ValW-1:2*ValW]; s_b = v1[3*ValW-1:2*ValW]; end
      2'd1: begin s_a = v0[2*ValW-1:ValW];   s_b = v1[2*ValW-1:ValW];   end
      default: begin s_a = v0[ValW-1:0];   s_b = v1[ValW-1:0];        end
    endcase
    d = {s_b[ValW-1], s_b} - {s_a[ValW-1], s_a};
  end
  logic signed [ValW+17:0] rnd;
  assign rnd = prod + (ValW+18)'(32768);
  // lcnt stops at 3 once all components are issued; a new sample clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      lcnt <= '0; pvalid <= 1'b0; lerp_done <= 1'b0;
    end else begin
      lerp_done <= 1'b0;
      pvalid <= 1'b0;
      if (cmd.lerp_step && lcnt != 2'd3) begin
        prod <= (ValW+18)'(d) * $signed({1'b0, fac});
        s_hold <= s_a;
        pvalid <= 1'b1;
        lcnt <= lcnt + 2'd1;
      end
      if (pvalid) begin
        res <= {res[2*ValW-1:0], ValW'(s_hold + ValW'(rnd >>> 16))};
        if (lcnt == 2'd3) lerp_done <= 1'b1;
      end
      if (cmd.latch) lcnt <= '0;
    end
  end
endmodule

// File: hw/rtl/kls_ctrl.sv
// Controller of the keyframe sampler: load, segment search and sequencing.
// Depends on kls_pkg.
`timescale 1ns / 1ps
module kls_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  opcode,
  input  logic [kls_pkg::CntW-1:0] key_count,
  input  logic [kls_pkg::TimeW-1:0] rd_time,
  input  logic [kls_pkg::TimeW-1:0] t_smp,
  input  logic [kls_pkg::AddrW-1:0] cache,
  input  kls_pkg::dp_stat_t     stat,
  output kls_pkg::dp_cmd_t      cmd,
  output logic [kls_pkg::AddrW-1:0] rd_addr,
  output logic [kls_pkg::AddrW-1:0] seg,
  output logic                  busy,
  output logic                  done,
  output kls_pkg::kind_t        kind
);
  import kls_pkg::*;

  typedef enum logic [3:0] {
    IDLE, CHK_RD, CHK, SCAN_RD, SCAN, RD_T0, RD_T1, RD_T2, DIV, LERP, SINGLE_RD, SINGLE
  } state_t;
  state_t state;

  logic [10:0] n;        // effective key count
  logic [AddrW:0] i;     // segment index under test
  logic from_zero;
  always_comb begin
    if (key_count == '0) n = 11'd1;
    else if (32'(key_count) > MaxKeys) n = 11'(MaxKeys);
    else n = 11'(key_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE; busy <= 1'b0; done <= 1'b0; cmd <= '0; kind <= KIND_LERP;
    end else begin
      cmd <= '0; done <= 1'b0;
      unique case (state)
        IDLE: if (start && !busy) begin
          if (opcode == OP_LOAD) cmd.load <= 1'b1;
          else begin
            busy <= 1'b1; cmd.latch <= 1'b1;
            if (n == 11'd1) begin
              rd_addr <= '0; cmd.rd <= 1'b1; state <= SINGLE_RD;
            end else if (11'(cache) + 11'd1 < n) begin
              rd_addr <= cache; cmd.rd <= 1'b1; state <= CHK_RD;
            end else begin
              i <= '0; from_zero <= 1'b1; state <= SCAN_RD;
            end
          end
        end
        CHK_RD: state <= CHK;
        CHK: begin
          i <= {1'b0, cache};
          from_zero <= (t_smp < rd_time);
          if (t_smp < rd_time) i <= '0;
          state <= SCAN_RD;
        end
        SCAN_RD: begin
          if (11'(i) + 11'd1 >= n) begin
            if (from_zero) begin
              kind <= KIND_NONE; done <= 1'b1; busy <= 1'b0; state <= IDLE;
            end else begin
              i <= '0; from_zero <= 1'b1;
            end
          end else begin
            rd_addr <= AddrW'(i + 1'b1); cmd.rd <= 1'b1; state <= SCAN;
          end
        end
        SCAN: state <= RD_T0;
        RD_T0: begin
          if (t_smp < rd_time) begin
            seg <= i[AddrW-1:0]; rd_addr <= i[AddrW-1:0]; cmd.rd <= 1'b1;
            state <= RD_T1;
          end else begin
            i <= i + 1'b1; state <= SCAN_RD;
          end
        end
        RD_T1: begin
          // start key is being read; order its capture and the end key read
          cmd.set_cache <= 1'b1; rd_addr <= AddrW'(seg + 1'b1); cmd.rd <= 1'b1;
          state <= RD_T2;
        end
        RD_T2: begin
          // order the factor start, which acts once the end key has been read
          cmd.div_start <= 1'b1; state <= DIV;
        end
        DIV: if (stat.div_done) begin
          cmd.lerp_step <= 1'b1; state <= LERP;
        end
        LERP: begin
          cmd.lerp_step <= 1'b1;
          if (stat.lerp_done) begin
            cmd.lerp_step <= 1'b0;
            kind <= KIND_LERP; done <= 1'b1; busy <= 1'b0; state <= IDLE;
          end
        end
        SINGLE_RD: state <= SINGLE;
        SINGLE: begin
          kind <= KIND_SINGLE; done <= 1'b1; busy <= 1'b0; state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// File: tb/tb_keyframe_linear_sampler_core.sv
// Self-checking testbench for keyframe_linear_sampler_core: directed table, then random loads and
// samples under three sender idling profiles, checked against a local track interpolator.
// Depends on kls_pkg and the RTL top level only.
`timescale 1ns / 1ps
module tb_keyframe_linear_sampler_core;
  import kls_pkg::*;

  localparam int NKeys = MaxKeys;
  localparam int InW = $bits(in_word_t);

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_word_t in_word;
  logic done;
  out_word_t out_word;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  keyframe_linear_sampler_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_word(in_word),
    .done(done), .out_word(out_word), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // local copy of the track and sampler state
  logic [TimeW-1:0] trk_time [NKeys];
  logic [ValW-1:0]  trk_x [NKeys];
  logic [ValW-1:0]  trk_y [NKeys];
  logic [ValW-1:0]  trk_z [NKeys];
  logic [SegW-1:0]  seg_cache;
  logic [CntW-1:0]  keys_in_use;

  out_word_t pending_q[$];
  int errors;
  int idle_pct;

  typedef struct {
    bit        is_cfg;
    logic [CntW-1:0] cfg;
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } row_t;
  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int eff_keys();
    if (keys_in_use == 0) return 1;
    if (int'(keys_in_use) > NKeys) return NKeys;
    return int'(keys_in_use);
  endfunction

  // start + ((end - start) * f + half) >> 16, floor shift
  function automatic logic [ValW-1:0] blend(logic [ValW-1:0] a, logic [ValW-1:0] b,
                                            longint f);
    longint s, d, p;
    s = longint'($signed(a));
    d = longint'($signed(b)) - s;
    p = d * f + 32768;
    return ValW'(s + (p >>> 16));
  endfunction

  function automatic bit seek_seg(int from, int n, logic [TimeW-1:0] t, output int seg);
    seg = 0;
    for (int i = from; i + 1 < n; i++) begin
      if (t < trk_time[i+1]) begin
        seg = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // apply one word to the local track; returns 1 with the result for a sample
  function automatic bit interpolate(in_word_t w, output out_word_t r);
    int n, seg;
    bit hit;
    logic [TimeW-1:0] t, t0, t1;
    longint f;
    r = '0;
    if (w.opcode == OP_LOAD) begin
      trk_time[w.key_index] = w.key_time;
      trk_x[w.key_index] = w.key_x;
      trk_y[w.key_index] = w.key_y;
      trk_z[w.key_index] = w.key_z;
      return 1'b0;
    end
    n = eff_keys();
    t = w.sample_time;
    if (n == 1) begin
      r.out_x = trk_x[0];
      r.out_y = trk_y[0];
      r.out_z = trk_z[0];
      r.status = ST_OK;
      return 1'b1;
    end
    hit = 1'b0;
    if (int'(seg_cache) + 1 < n && t >= trk_time[seg_cache])
      hit = seek_seg(int'(seg_cache), n, t, seg);
    if (!hit) hit = seek_seg(0, n, t, seg);
    if (!hit) begin
      r.status = ST_NO_SEG;
      return 1'b1;
    end
    seg_cache = SegW'(seg);
    t0 = trk_time[seg];
    t1 = trk_time[seg+1];
    if (t1 <= t0 || t <= t0) f = 0;
    else if (t - t0 >= t1 - t0) f = 65536;
    else f = (longint'(t - t0) << 16) / longint'(t1 - t0);
    r.out_x = blend(trk_x[seg], trk_x[seg+1], f);
    r.out_y = blend(trk_y[seg], trk_y[seg+1], f);
    r.out_z = blend(trk_z[seg], trk_z[seg+1], f);
    r.segment = SegW'(seg);
    r.status = ST_OK;
    return 1'b1;
  endfunction

  // hand one word over; typed expectation replaces the predicted one if given
  task automatic send_word(in_word_t w, bit typed = 1'b0, out_word_t want = '0);
    out_word_t r;
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    if (interpolate(w, r)) pending_q.push_back(typed ? want : r);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // drain outstanding results, then program key_count
  task automatic set_keys(logic [CntW-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_KEY_COUNT;
    pwdata <= {$urandom} & ~32'h7F | 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    keys_in_use = v;
    @(posedge clk);
  endtask

  function automatic in_word_t noise_word();
    in_word_t w;
    w = InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return w;
  endfunction

  function automatic in_word_t load_word(int k, logic [TimeW-1:0] t, logic [31:0] x,
                                         logic [31:0] y, logic [31:0] z);
    in_word_t w;
    w = noise_word();
    w.opcode = OP_LOAD;
    w.key_index = 6'(k);
    w.key_time = t;
    w.key_x = x;
    w.key_y = y;
    w.key_z = z;
    return w;
  endfunction

  function automatic in_word_t sample_word(logic [TimeW-1:0] t);
    in_word_t w;
    w = noise_word();
    w.opcode = OP_SAMPLE;
    w.sample_time = t;
    return w;
  endfunction

  function automatic void add_row(bit is_cfg, logic [CntW-1:0] c, in_word_t w,
                                  bit typed = 1'b0, out_word_t want = '0);
    row_t r;
    r.is_cfg = is_cfg;
    r.cfg = c;
    r.w = w;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endfunction

  // monotonic track over all slots
  task automatic load_track();
    logic [TimeW-1:0] t;
    t = TimeW'($urandom_range(0, 255));
    for (int k = 0; k < NKeys; k++) begin
      send_word(load_word(k, t, $urandom, $urandom, $urandom));
      t = t + TimeW'($urandom_range(1, 'h3FFF));
    end
  endtask

  task automatic random_item();
    int n, k, sel;
    logic [TimeW-1:0] lo, hi;
    n = eff_keys();
    sel = $urandom_range(99);
    if (sel < 12) begin
      // rewrite a key, keeping its time
      k = $urandom_range(NKeys - 1);
      send_word(load_word(k, trk_time[k], $urandom, $urandom, $urandom));
    end else if (sel < 18) begin
      // noise: key at an arbitrary time
      send_word(load_word($urandom_range(NKeys - 1), TimeW'($urandom), $urandom,
                          $urandom, $urandom));
    end else begin
      lo = trk_time[0];
      hi = trk_time[n-1];
      sel = $urandom_range(99);
      if (sel < 65 && hi > lo) send_word(sample_word(TimeW'($urandom_range(lo, hi))));
      else if (sel < 82) send_word(sample_word(trk_time[$urandom_range(n - 1)]));
      else send_word(sample_word(TimeW'($urandom)));
    end
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_word);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_word.out_x !== e.out_x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.out_x, out_word.out_x);
          errors++;
        end
        if (out_word.out_y !== e.out_y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.out_y, out_word.out_y);
          errors++;
        end
        if (out_word.out_z !== e.out_z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.out_z, out_word.out_z);
          errors++;
        end
        if (out_word.segment !== e.segment) begin
          $display("%0t: segment expected %0d actual %0d", $time, e.segment,
                   out_word.segment);
          errors++;
        end
        if (out_word.status !== e.status) begin
          $display("%0t: status expected %b actual %b", $time, e.status, out_word.status);
          errors++;
        end
      end
    end
  end

  initial begin
    static int counts[15] = '{2, 64, 0, 127, 1, 5, 33, 64, 2, 96, 64, 9, 3, 127, 40};
    static int profile[3] = '{26, 81, 0};
    out_word_t k0, none;
    int waited;
    errors = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    in_word = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < NKeys; i++) begin
      trk_time[i] = '0;
      trk_x[i] = '0;
      trk_y[i] = '0;
      trk_z[i] = '0;
    end
    seg_cache = '0;
    keys_in_use = 7'd1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    k0 = '0;
    k0.out_x = 32'h7FFF_FFFF;
    k0.out_y = 32'h8000_0000;
    k0.status = ST_OK;
    none = '0;
    none.status = ST_NO_SEG;
    add_row(1, 7'd1, '0);
    add_row(0, 0, load_word(0, 24'h000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    add_row(0, 0, sample_word(24'h000000), 1, k0);
    add_row(0, 0, sample_word(24'hFFFFFF), 1, k0);
    add_row(1, 7'd0, '0);
    add_row(0, 0, sample_word(24'h000123), 1, k0);
    add_row(0, 0, load_word(1, 24'h000100, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1));
    add_row(0, 0, load_word(2, 24'h000200, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000));
    add_row(0, 0, load_word(3, 24'h000300, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF));
    add_row(0, 0, load_word(63, 24'hFFFFFF, 32'h1234_5678, 32'h8765_4321, 32'h0));
    add_row(1, 7'd4, '0);
    add_row(0, 0, sample_word(24'h000080));
    add_row(0, 0, sample_word(24'h000300), 1, none);
    add_row(0, 0, sample_word(24'hFFFFFF), 1, none);
    add_row(0, 0, sample_word(24'h000250));
    add_row(0, 0, sample_word(24'h000050));   // precedes cached segment start
    add_row(0, 0, sample_word(24'h000100));   // exactly on a key
    add_row(0, 0, sample_word(24'h0002FF));
    add_row(0, 0, load_word(2, 24'h0000C0, 32'h4000_0000, 32'hC000_0000, 32'h5));
    add_row(0, 0, sample_word(24'h0000F0));   // times no longer increasing
    add_row(0, 0, sample_word(24'h000150));
    add_row(0, 0, sample_word(24'h0000A0));
    foreach (rows[i]) begin
      if (rows[i].is_cfg) set_keys(rows[i].cfg);
      else send_word(rows[i].w, rows[i].typed, rows[i].want);
    end

    // random phases, one per idling profile
    for (int p = 0; p < 3; p++) begin
      idle_pct = profile[p];
      load_track();
      for (int b = 0; b < 5; b++) begin
        set_keys(7'(counts[p*5+b]));
        repeat (95) random_item();
      end
    end

    start <= 1'b0;
    waited = 0;
    while (pending_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (500) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (pending_q.size() != 0)
        $display("%0t: %0d expected result words never arrived", $time, pending_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/kls_pkg.sv
hw/rtl/kls_datapath.sv
hw/rtl/kls_ctrl.sv
hw/rtl/keyframe_linear_sampler_core.sv
tb/tb_keyframe_linear_sampler_core.sv
